// ===== design/vtpd_pkg.sv =====
package vtpd_pkg;

    // register file layout: two coefficients per register, four rows of four
    localparam int CFG_NUM    = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int COEF_W     = 32;
    localparam int ROWS       = 4;
    localparam int COLS       = 4;
    localparam int LANES      = 3;
    localparam int W_ROW      = 3;
    localparam int FIELD_W    = 32;

    typedef struct packed {
        logic signed [FIELD_W-1:0] in_x;
        logic signed [FIELD_W-1:0] in_y;
        logic signed [FIELD_W-1:0] in_z;
    } vtx_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic signed [FIELD_W-1:0] out_z;
        logic                      w_zero;
    } vtx_out_t;

    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_word_t;

endpackage

// ===== design/vertex_transform_perspective_divide.sv =====
// channel | direction | payload                       | handshake
// --------+-----------+-------------------------------+-----------------------
// in      | in        | vtx_in_t  (in_x, in_y, in_z)  | in_valid / in_ready
// out     | out       | vtx_out_t (out_x..z, w_zero)  | out_valid / out_ready
// cfg     | in        | cfg_index, cfg_data           | cfg_valid / cfg_ready
//
// one transaction per cycle sustained while out_ready is high; stages in order
// (multiply, row sum, divide setup, one quotient bit per divider stage, output)
// the depth is set by the bit-per-stage restoring divider, three lanes wide
// reset clears the valid bits and loads the identity matrix
// each full stage holds while its successor is full and stalled, so bubbles are
// squeezed out and nothing is dropped or repeated
module vertex_transform_perspective_divide #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vtpd_pkg::vtx_in_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vtpd_pkg::vtx_out_t   out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  vtpd_pkg::cfg_idx_t   cfg_index,
    input  vtpd_pkg::cfg_word_t  cfg_data
);
    import vtpd_pkg::*;

    // product, row sum, floored row value and divider widths
    localparam int PW  = 2 * COEF_W;
    localparam int SW  = PW + 2;
    localparam int TW  = SW - FRAC_BITS;
    localparam int RW  = TW + COORD_WIDTH + 1;
    localparam int NST = COORD_WIDTH;
    localparam int QW  = COORD_WIDTH + 1;
    localparam logic [QW-1:0] LIM = QW'(1) << (COORD_WIDTH - 1);

    // matrix registers
    cfg_word_t mat_reg [CFG_NUM];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // identity: 1.0 on the diagonal
            mat_reg[0] <= CFG_DATA_W'(1) << FRAC_BITS;
            mat_reg[1] <= '0;
            mat_reg[2] <= CFG_DATA_W'(1) << (COEF_W + FRAC_BITS);
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= CFG_DATA_W'(1) << FRAC_BITS;
            mat_reg[6] <= '0;
            mat_reg[7] <= CFG_DATA_W'(1) << (COEF_W + FRAC_BITS);
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(CFG_NUM)))
        begin
            mat_reg[cfg_index[$clog2(CFG_NUM)-1:0]] <= cfg_data;
        end
    end

    // stage valids and the ready chain, back to front
    logic                  v1_reg, v2_reg, out_valid_reg;
    logic                  dv_reg   [NST+1];
    logic                  drdy     [NST+1];
    logic                  rdy1, rdy2, rdy_o;

    assign rdy_o    = !out_valid_reg || out_ready;
    always_comb
    begin
        drdy[NST] = !dv_reg[NST] || rdy_o;
        for (int k = NST - 1; k >= 0; k--)
        begin
            drdy[k] = !dv_reg[k] || drdy[k+1];
        end
    end
    assign rdy2     = !v2_reg || drdy[0];
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = out_valid_reg;

    // stage 1: twelve products, w column only needs the coefficient
    logic signed [COEF_W-1:0] crd [LANES];
    logic signed [PW-1:0]     prod_reg  [ROWS][LANES];
    logic signed [PW-1:0]     prod_next [ROWS][LANES];
    logic signed [COEF_W-1:0] wcoef_reg  [ROWS];
    logic signed [COEF_W-1:0] wcoef_next [ROWS];

    assign crd[0] = COEF_W'(signed'(in_data.in_x[COORD_WIDTH-1:0]));
    assign crd[1] = COEF_W'(signed'(in_data.in_y[COORD_WIDTH-1:0]));
    assign crd[2] = COEF_W'(signed'(in_data.in_z[COORD_WIDTH-1:0]));

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                prod_next[r][c] = $signed(mat_reg[2*r + c/2][COEF_W*(c%2) +: COEF_W])
                                  * crd[c];
            end
            wcoef_next[r] = $signed(mat_reg[2*r + 1][COEF_W +: COEF_W]);
        end
    end

    // stage 2: exact row sums, floored by the fraction bits
    logic signed [SW-1:0] sum_n  [ROWS];
    logic signed [TW-1:0] t_reg  [ROWS];
    logic signed [TW-1:0] t_next [ROWS];

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            sum_n[r] = SW'(prod_reg[r][0]) + SW'(prod_reg[r][1]) + SW'(prod_reg[r][2])
                       + (SW'(wcoef_reg[r]) <<< FRAC_BITS);
            t_next[r] = TW'(sum_n[r] >>> FRAC_BITS);
        end
    end

    // stage 3 (divider slot 0): magnitudes, signs, overflow and zero w
    // divider slots 1..NST: one restoring quotient bit each, msb first
    logic [RW-1:0]          drem_reg  [NST+1][LANES];
    logic [RW-1:0]          drem_next [NST+1][LANES];
    logic [NST-1:0]         dq_reg    [NST+1][LANES];
    logic [NST-1:0]         dq_next   [NST+1][LANES];
    logic                   dneg_reg  [NST+1][LANES];
    logic                   dneg_next [NST+1][LANES];
    logic                   dovf_reg  [NST+1][LANES];
    logic                   dovf_next [NST+1][LANES];
    logic [TW-1:0]          dd_reg    [NST+1];
    logic [TW-1:0]          dd_next   [NST+1];
    logic                   dwz_reg   [NST+1];
    logic                   dwz_next  [NST+1];
    logic [TW-1:0]          mag       [LANES];
    logic [RW:0]            sub       [NST][LANES];

    always_comb
    begin
        dd_next[0]  = t_reg[W_ROW][TW-1] ? unsigned'(-t_reg[W_ROW]) : unsigned'(t_reg[W_ROW]);
        dwz_next[0] = (t_reg[W_ROW] == '0);
        for (int c = 0; c < LANES; c++)
        begin
            mag[c]          = t_reg[c][TW-1] ? unsigned'(-t_reg[c]) : unsigned'(t_reg[c]);
            dneg_next[0][c] = t_reg[c][TW-1] ^ t_reg[W_ROW][TW-1];
            drem_next[0][c] = RW'(mag[c]) << FRAC_BITS;
            // quotient would need more than COORD_WIDTH bits
            dovf_next[0][c] = drem_next[0][c] >= (RW'(dd_next[0]) << COORD_WIDTH);
            dq_next[0][c]   = '0;
        end
        for (int k = 0; k < NST; k++)
        begin
            dd_next[k+1]  = dd_reg[k];
            dwz_next[k+1] = dwz_reg[k];
            for (int c = 0; c < LANES; c++)
            begin
                sub[k][c] = {1'b0, drem_reg[k][c]}
                            - {1'b0, RW'(dd_reg[k]) << (NST - 1 - k)};
                drem_next[k+1][c] = sub[k][c][RW] ? drem_reg[k][c] : sub[k][c][RW-1:0];
                dq_next[k+1][c]   = {dq_reg[k][c][NST-2:0], !sub[k][c][RW]};
                dneg_next[k+1][c] = dneg_reg[k][c];
                dovf_next[k+1][c] = dovf_reg[k][c];
            end
        end
    end

    // output stage: saturate and apply sign, zero the result when w is zero
    logic [QW-1:0]            qx   [LANES];
    logic [COORD_WIDTH-1:0]   res  [LANES];
    vtx_out_t                 out_next;
    vtx_out_t                 out_reg;

    always_comb
    begin
        for (int c = 0; c < LANES; c++)
        begin
            qx[c] = dovf_reg[NST][c] ? LIM : {1'b0, dq_reg[NST][c]};
            if (dneg_reg[NST][c])
            begin
                if (qx[c] > LIM)
                begin
                    qx[c] = LIM;
                end
                res[c] = COORD_WIDTH'(-qx[c]);
            end
            else
            begin
                if (qx[c] > LIM - QW'(1))
                begin
                    qx[c] = LIM - QW'(1);
                end
                res[c] = COORD_WIDTH'(qx[c]);
            end
            if (dwz_reg[NST])
            begin
                res[c] = '0;
            end
        end
        out_next.out_x  = FIELD_W'(signed'(res[0]));
        out_next.out_y  = FIELD_W'(signed'(res[1]));
        out_next.out_z  = FIELD_W'(signed'(res[2]));
        out_next.w_zero = dwz_reg[NST];
    end

    assign out_data = out_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= NST; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (drdy[0])
            begin
                dv_reg[0] <= v2_reg;
            end
            for (int k = 1; k <= NST; k++)
            begin
                if (drdy[k])
                begin
                    dv_reg[k] <= dv_reg[k-1];
                end
            end
            if (rdy_o)
            begin
                out_valid_reg <= dv_reg[NST];
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            prod_reg  <= prod_next;
            wcoef_reg <= wcoef_next;
        end
        if (rdy2)
        begin
            t_reg <= t_next;
        end
        for (int k = 0; k <= NST; k++)
        begin
            if (drdy[k])
            begin
                drem_reg[k] <= drem_next[k];
                dq_reg[k]   <= dq_next[k];
                dneg_reg[k] <= dneg_next[k];
                dovf_reg[k] <= dovf_next[k];
                dd_reg[k]   <= dd_next[k];
                dwz_reg[k]  <= dwz_next[k];
            end
        end
        if (rdy_o)
        begin
            out_reg <= out_next;
        end
    end

endmodule
